>>> src/kce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_pkg
// Shared types, widths and codes of the k-combination enumerator.
// ----------------------------------------------------------------------------
package kce_pkg;

    // Field widths of the channels
    localparam int SET_SIZE_W    = 7;
    localparam int SUBSET_SIZE_W = 5;
    localparam int SLOT_W        = 4;
    localparam int ELEMENT_W     = 6;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 7;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSET_SIZE = 2'd1;

    // Register reset values
    localparam logic [SET_SIZE_W-1:0]    RST_SET_SIZE    = 7'd8;
    localparam logic [SUBSET_SIZE_W-1:0] RST_SUBSET_SIZE = 5'd2;

    // Parameter defaults
    localparam int MAX_SUBSET_DEF = 16;
    localparam int MAX_SET_DEF    = 64;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_DONE
    } t_state;

    // Sizes seen by the sequencer
    typedef struct packed {
        logic [SET_SIZE_W-1:0]    n_eff;
        logic [SUBSET_SIZE_W-1:0] k;
        logic                     clr;
    } t_cfg;

endpackage

>>> src/kce_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface kce_req_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface kce_res_if;
    logic                          valid;
    logic                          ready;
    logic [kce_pkg::SLOT_W-1:0]    slot;
    logic [kce_pkg::ELEMENT_W-1:0] element;
    logic                          last;
    logic                          done_res;
    modport source (output valid, output slot, output element, output last,
                    output done_res, input ready);
    modport sink   (input valid, input slot, input element, input last,
                    input done_res, output ready);
endinterface

interface kce_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [kce_pkg::CFG_IDX_W-1:0]  index;
    logic [kce_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/kce_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/kce_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_cfg
// Size registers; clamps n to the set capacity and flags each size write.
// ----------------------------------------------------------------------------
module kce_cfg #(
    parameter int MAX_SET = kce_pkg::MAX_SET_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kce_cfg_if.sink       i_cfg,
    output kce_pkg::t_cfg o_cfg
);

    logic [kce_pkg::SET_SIZE_W-1:0]    r_set_size;
    logic [kce_pkg::SUBSET_SIZE_W-1:0] r_subset_size;
    logic                              w_wr;

    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid && i_cfg.ready;

    // Take register writes, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size    <= kce_pkg::RST_SET_SIZE;
            r_subset_size <= kce_pkg::RST_SUBSET_SIZE;
        end else if (w_wr) begin
            case (i_cfg.index)
                kce_pkg::REG_SET_SIZE:
                    r_set_size <= kce_pkg::SET_SIZE_W'(i_cfg.data);
                kce_pkg::REG_SUBSET_SIZE:
                    r_subset_size <= kce_pkg::SUBSET_SIZE_W'(i_cfg.data);
                default: ;
            endcase
        end
    end

    // Clamp n and flag writes that restart the enumeration
    always_comb begin
        o_cfg.k     = r_subset_size;
        o_cfg.clr   = w_wr && (i_cfg.index == kce_pkg::REG_SET_SIZE ||
                               i_cfg.index == kce_pkg::REG_SUBSET_SIZE);
        o_cfg.n_eff = (int'(r_set_size) > MAX_SET) ?
                      kce_pkg::SET_SIZE_W'(MAX_SET) : r_set_size;
    end

endmodule

>>> src/kce_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_seq
// Sequencer: scans the stored subset for the position to grow, then reads
// back and rewrites the subset, one index per cycle while not stalled.
// ----------------------------------------------------------------------------
module kce_seq #(
    parameter int MAX_SUBSET = kce_pkg::MAX_SUBSET_DEF,
    parameter int MAX_SET    = kce_pkg::MAX_SET_DEF,
    localparam int IW  = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1,
    localparam int CW  = $clog2(MAX_SUBSET + 1),
    localparam int EW0 = $clog2(MAX_SET),
    localparam int EW  = (EW0 > 7) ? 7 : EW0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kce_pkg::t_cfg i_cfg,
    kce_req_if.sink       i_req,
    kce_res_if.source     o_res,
    output logic          o_we,
    output logic [IW-1:0] o_waddr,
    output logic [EW-1:0] o_wdata,
    output logic [IW-1:0] o_raddr,
    input  logic [EW-1:0] i_rdata
);

    kce_pkg::t_state r_state, n_state;

    logic          r_started, r_exh;
    logic [IW-1:0] r_si, r_ci, r_pos, r_bi;
    logic          r_chk, r_bv;
    logic [EW-1:0] r_base;
    logic [CW-1:0] r_ni;

    logic                          r_out_valid, r_last, r_done;
    logic [kce_pkg::SLOT_W-1:0]    r_slot;
    logic [kce_pkg::ELEMENT_W-1:0] r_elem;

    logic                                w_acc, w_fresh, w_bad, w_ld, w_take;
    logic                                w_issue, w_b_last, w_found, w_gen;
    logic [kce_pkg::SET_SIZE_W-1:0]      w_lim;
    logic [7:0]                          w_scan_max, w_gen_sum;
    logic [EW-1:0]                       w_gen_val, w_elem;

    // Request decode
    assign w_acc   = i_req.valid && i_req.ready;
    assign w_fresh = i_req.restart || !r_started;
    assign w_bad   = (i_cfg.k == '0) || (int'(i_cfg.k) > MAX_SUBSET) ||
                     ({2'b00, i_cfg.k} > i_cfg.n_eff);

    // Output register frees up this cycle
    assign w_ld = !r_out_valid || o_res.ready;

    // Scan compare: position ci is at its top when value == n - k + ci
    assign w_lim      = i_cfg.n_eff - {2'b00, i_cfg.k};
    assign w_scan_max = {1'b0, w_lim} + 8'(r_ci);
    assign w_found    = r_chk && (8'(i_rdata) < w_scan_max);

    // Emit stage: positions from pos on are refilled consecutively
    assign w_issue   = int'(r_ni) < int'(i_cfg.k);
    assign w_take    = (r_state == kce_pkg::ST_EMIT) && r_bv && w_ld;
    assign w_b_last  = (int'(r_bi) + 1) == int'(i_cfg.k);
    assign w_gen     = r_bi >= r_pos;
    assign w_gen_sum = 8'(r_base) + 8'(r_bi - r_pos);
    assign w_gen_val = EW'(w_gen_sum);
    assign w_elem    = w_gen ? w_gen_val : i_rdata;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kce_pkg::ST_IDLE: begin
                if (w_acc) begin
                    if (w_fresh) begin
                        n_state = w_bad ? kce_pkg::ST_DONE : kce_pkg::ST_EMIT;
                    end else if (r_exh) begin
                        n_state = kce_pkg::ST_DONE;
                    end else begin
                        n_state = kce_pkg::ST_SCAN;
                    end
                end
            end
            kce_pkg::ST_SCAN: begin
                if (w_found) begin
                    n_state = kce_pkg::ST_EMIT;
                end else if (r_chk && r_ci == '0) begin
                    n_state = kce_pkg::ST_DONE;
                end
            end
            kce_pkg::ST_EMIT: begin
                if (w_take && w_b_last) begin
                    n_state = kce_pkg::ST_IDLE;
                end
            end
            kce_pkg::ST_DONE: begin
                if (w_ld) begin
                    n_state = kce_pkg::ST_IDLE;
                end
            end
            default: n_state = kce_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the state machine
    always_comb begin
        i_req.ready = 1'b0;
        o_raddr     = IW'(r_ni);
        o_we        = 1'b0;
        case (r_state)
            kce_pkg::ST_IDLE: i_req.ready = 1'b1;
            kce_pkg::ST_SCAN: o_raddr = r_si;
            kce_pkg::ST_EMIT: begin
                o_raddr = (r_bv && !w_ld) ? r_bi : IW'(r_ni);
                o_we    = w_take && w_gen;
            end
            default: ;
        endcase
    end

    assign o_waddr = r_bi;
    assign o_wdata = w_gen_val;

    always_ff @(posedge i_clk) begin
        r_state <= i_rst_n ? n_state : kce_pkg::ST_IDLE;
    end

    // Enumeration flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_exh     <= 1'b0;
        end else begin
            if (i_cfg.clr) begin
                r_started <= 1'b0;
            end else if (w_acc && w_fresh) begin
                r_started <= 1'b1;
                r_exh     <= w_bad;
            end
            if (r_state == kce_pkg::ST_SCAN && !w_found && r_chk && r_ci == '0) begin
                r_exh <= 1'b1;
            end
        end
    end

    // Scan and emit pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk <= 1'b0;
            r_bv  <= 1'b0;
        end else begin
            case (r_state)
                kce_pkg::ST_IDLE: begin
                    r_si   <= IW'(i_cfg.k - 5'd1);
                    r_chk  <= 1'b0;
                    r_bv   <= 1'b0;
                    r_ni   <= '0;
                    r_pos  <= '0;
                    r_base <= '0;
                end
                kce_pkg::ST_SCAN: begin
                    if (w_found) begin
                        r_pos  <= r_ci;
                        r_base <= i_rdata + EW'(1);
                    end else begin
                        r_ci  <= r_si;
                        r_chk <= 1'b1;
                        if (r_si != '0) begin
                            r_si <= r_si - IW'(1);
                        end
                    end
                end
                kce_pkg::ST_EMIT: begin
                    if (!r_bv || w_ld) begin
                        r_bv <= w_issue;
                        if (w_issue) begin
                            r_bi <= IW'(r_ni);
                            r_ni <= r_ni + CW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take || (r_state == kce_pkg::ST_DONE && w_ld)) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_slot <= kce_pkg::SLOT_W'(r_bi);
            r_elem <= kce_pkg::ELEMENT_W'(w_elem);
            r_last <= w_b_last;
            r_done <= 1'b0;
        end else if (r_state == kce_pkg::ST_DONE && w_ld) begin
            r_slot <= '0;
            r_elem <= '0;
            r_last <= 1'b0;
            r_done <= 1'b1;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.slot     = r_slot;
    assign o_res.element  = r_elem;
    assign o_res.last     = r_last;
    assign o_res.done_res = r_done;

endmodule

>>> src/k_combination_enumerator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_combination_enumerator
// Lists the k-element subsets of 0..n-1 in lexicographic order, one subset
// per request, emitted as k indices in ascending order.
//
//   channel   dir   payload                          transaction
//   i_req     in    restart                          one request
//   o_res     out   slot, element, last, done_res    one index or done
//   i_cfg     in    index, data                      one register write
//
// Restart (or a first request) emits the first subset directly; an advance
// scans down from the top entry to growing position p, then emits k indices.
// Both walk the single read port of the subset RAM one entry per cycle.
// Reset is synchronous, active low; the subset RAM needs no clearing.
// A stalled result holds the emit walk; i_req is taken only between requests.
// ----------------------------------------------------------------------------
module k_combination_enumerator #(
    parameter int MAX_SUBSET = kce_pkg::MAX_SUBSET_DEF,
    parameter int MAX_SET    = kce_pkg::MAX_SET_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    kce_req_if.sink   i_req,
    kce_res_if.source o_res,
    kce_cfg_if.sink   i_cfg
);

    localparam int IW  = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;
    localparam int EW0 = $clog2(MAX_SET);
    localparam int EW  = (EW0 > 7) ? 7 : EW0;

    kce_pkg::t_cfg w_cfg;
    logic          w_we;
    logic [IW-1:0] w_waddr, w_raddr;
    logic [EW-1:0] w_wdata, w_rdata;

    // Size registers
    kce_cfg #(
        .MAX_SET (MAX_SET)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // Sequencer
    kce_seq #(
        .MAX_SUBSET (MAX_SUBSET),
        .MAX_SET    (MAX_SET)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_req   (i_req),
        .o_res   (o_res),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata),
        .o_raddr (w_raddr),
        .i_rdata (w_rdata)
    );

    // Current subset store
    kce_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SUBSET)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule
